FILE: rtl/lmh_pkg.sv
// Package for the log-magnitude heatmap pixel block: constants, types, log ROM builder.
`default_nettype none
package lmh_pkg;

   localparam int LOG_ADDR_BITS = 10;
   localparam int COORD_BITS    = 12;
   localparam int LOG_DEPTH     = 1 << LOG_ADDR_BITS;
   localparam int LOG_FRAC_BITS = 24;
   localparam logic [63:0] LOG_SCALE = 64'd646456993;

   // Coordinate ports are 12 bits; keep at most COORD_BITS of them
   localparam logic [11:0] COORD_MASK =
      (COORD_BITS >= 12) ? 12'hFFF : 12'((64'd1 << COORD_BITS) - 64'd1);

   typedef logic [15:0] level_type;
   typedef level_type log_rom_type [LOG_DEPTH];

   typedef enum logic [1:0] {
      SEG_BLACK_BLUE = 2'd0,
      SEG_BLUE_CYAN  = 2'd1,
      SEG_WHITE_PINK = 2'd2,
      SEG_RED_BLACK  = 2'd3
   } segment_type;

   // Pixel placement carried alongside the level lookup
   typedef struct packed {
      logic        valid;
      logic [11:0] pixel_x;
      logic [11:0] pixel_y;
   } pix_stage_type;

   // log2 in Q.24 by repeated squaring; elaboration time only
   function automatic logic [63:0] log2_q24(input logic [31:0] n);
      logic [5:0]  e;
      logic [63:0] m;
      logic [63:0] frac;
      e    = '0;
      frac = '0;
      if (n == 32'd0) begin
         return 64'd0;
      end
      for (int i = 0; i < 32; i++) begin
         if (n[i]) begin
            e = 6'(i);
         end
      end
      m = ({32'd0, n} << (6'd30 - e)) & 64'hFFFF_FFFF;
      for (int i = 0; i < LOG_FRAC_BITS; i++) begin
         m    = (m * m) >> 30;
         frac = frac << 1;
         if (m >= (64'd1 << 31)) begin
            m    = m >> 1;
            frac = frac | 64'd1;
         end
      end
      return ({58'd0, e} << LOG_FRAC_BITS) | frac;
   endfunction

   function automatic level_type log_level(input logic [LOG_ADDR_BITS-1:0] addr);
      logic [31:0] q;
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] d;
      logic [63:0] lv;
      q  = 32'(addr) << (16 - LOG_ADDR_BITS);
      a  = log2_q24(32'd65535 + 32'd100 * q);
      b  = log2_q24(32'd65535);
      d  = (a > b) ? (a - b) : 64'd0;
      lv = (d * LOG_SCALE) >> 40;
      return (lv > 64'd65535) ? 16'hFFFF : lv[15:0];
   endfunction

   function automatic log_rom_type build_log_rom();
      log_rom_type t;
      for (int i = 0; i < LOG_DEPTH; i++) begin
         t[i] = log_level(LOG_ADDR_BITS'(i));
      end
      return t;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/lmh_log_rom.sv
// Log compression ROM with registered read.
`default_nettype none
module lmh_log_rom (
   input  wire logic                             clock,
   input  wire logic [lmh_pkg::LOG_ADDR_BITS-1:0] addr,
   output lmh_pkg::level_type                    level_ff
);
   import lmh_pkg::*;

   localparam log_rom_type LogTable = build_log_rom();

   always_ff @(posedge clock) begin
      level_ff <= LogTable[addr];
   end

endmodule
`default_nettype wire

FILE: rtl/lmh_colormap.sv
// Heat colormap: four linear segments, result register.
`default_nettype none
module lmh_colormap (
   input  wire logic               clock,
   input  wire logic               reset,
   input  lmh_pkg::level_type      level,
   input  lmh_pkg::pix_stage_type  stage,
   output logic                    rsp_strobe,
   output logic [11:0]             rsp_pixel_x,
   output logic [11:0]             rsp_pixel_y,
   output logic [7:0]              rsp_red,
   output logic [7:0]              rsp_green,
   output logic [7:0]              rsp_blue
);
   import lmh_pkg::*;

   // base +/- u*k/2^14; falling terms round the product up so the channel truncates
   function automatic logic [7:0] heat_channel(input logic [13:0] u, input logic [7:0] k,
                                               input logic [7:0] base, input logic falling);
      logic [21:0] prod;
      logic [21:0] adj;
      logic [7:0]  term;
      prod = 22'(u) * 22'(k);
      adj  = falling ? (prod + 22'd16383) : prod;
      term = adj[21:14];
      return falling ? (base - term) : (base + term);
   endfunction

   segment_type seg;
   logic [13:0] u;
   logic [7:0]  red_in;
   logic [7:0]  green_in;
   logic [7:0]  blue_in;
   logic        strobe_ff;
   logic [11:0] x_ff;
   logic [11:0] y_ff;
   logic [7:0]  red_ff;
   logic [7:0]  green_ff;
   logic [7:0]  blue_ff;

   assign seg = segment_type'(level[15:14]);
   assign u   = level[13:0];

   always_comb begin
      unique case (seg)
         SEG_BLACK_BLUE: begin
            red_in   = heat_channel(u, 8'd20, 8'd0, 1'b0);
            green_in = heat_channel(u, 8'd40, 8'd0, 1'b0);
            blue_in  = heat_channel(u, 8'd195, 8'd60, 1'b0);
         end
         SEG_BLUE_CYAN: begin
            red_in   = heat_channel(u, 8'd235, 8'd20, 1'b0);
            green_in = heat_channel(u, 8'd160, 8'd40, 1'b0);
            blue_in  = 8'd255;
         end
         SEG_WHITE_PINK: begin
            red_in   = 8'd255;
            green_in = heat_channel(u, 8'd130, 8'd200, 1'b1);
            blue_in  = heat_channel(u, 8'd200, 8'd255, 1'b1);
         end
         SEG_RED_BLACK: begin
            red_in   = 8'd255;
            green_in = heat_channel(u, 8'd70, 8'd70, 1'b1);
            blue_in  = heat_channel(u, 8'd55, 8'd55, 1'b1);
         end
         default: begin
            red_in   = 8'd0;
            green_in = 8'd0;
            blue_in  = 8'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= stage.valid;
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= stage.pixel_x;
      y_ff     <= stage.pixel_y;
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
   end

   assign rsp_strobe  = strobe_ff;
   assign rsp_pixel_x = x_ff;
   assign rsp_pixel_y = y_ff;
   assign rsp_red     = red_ff;
   assign rsp_green   = green_ff;
   assign rsp_blue    = blue_ff;

endmodule
`default_nettype wire

FILE: rtl/log_magnitude_heatmap_pixel_top.sv
// Top level of the log-magnitude heatmap pixel block.
// Path from start to rsp_strobe: log ROM read register, then colormap register.
// Throughput: one item per cycle; busy is low whenever reset is low.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset (synchronous, active high) clears the pipeline valids and sets image_height to 256.
`default_nettype none
module log_magnitude_heatmap_pixel_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [11:0] req_row,
   input  wire logic [11:0] req_column,
   input  wire logic [15:0] req_bin_value,
   output logic             rsp_strobe,
   output logic [11:0]      rsp_pixel_x,
   output logic [11:0]      rsp_pixel_y,
   output logic [7:0]       rsp_red,
   output logic [7:0]       rsp_green,
   output logic [7:0]       rsp_blue,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [12:0] csr_image_height
);
   import lmh_pkg::*;

   logic [12:0]   height_ff;
   logic [12:0]   flip_row;
   logic          accept;
   pix_stage_type stage_in;
   pix_stage_type stage_ff;
   level_type     level_ff;

   assign busy      = reset;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= 13'd256;
      end else if (csr_valid && csr_ready) begin
         height_ff <= csr_image_height;
      end
   end

   // row counts from the bottom; wraps when not below the height
   assign flip_row = height_ff - 13'd1 - {1'b0, req_row};

   always_comb begin
      stage_in.valid   = accept;
      stage_in.pixel_x = req_column & COORD_MASK;
      stage_in.pixel_y = flip_row[11:0] & COORD_MASK;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.pixel_x <= stage_in.pixel_x;
      stage_ff.pixel_y <= stage_in.pixel_y;
   end

   lmh_log_rom u_log_rom (
      .clock    (clock),
      .addr     (req_bin_value[15 -: LOG_ADDR_BITS]),
      .level_ff (level_ff)
   );

   lmh_colormap u_colormap (
      .clock       (clock),
      .reset       (reset),
      .level       (level_ff),
      .stage       (stage_ff),
      .rsp_strobe  (rsp_strobe),
      .rsp_pixel_x (rsp_pixel_x),
      .rsp_pixel_y (rsp_pixel_y),
      .rsp_red     (rsp_red),
      .rsp_green   (rsp_green),
      .rsp_blue    (rsp_blue)
   );

   a_accept_to_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 rsp_strobe)
      else $error("accepted item produced no result");

   a_result_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(stage_ff.valid))
      else $error("result strobe without an item in flight");

   a_column_carried: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_pixel_x == ($past(req_column, 2) & COORD_MASK))
      else $error("pixel_x does not match accepted column");

   a_upper_half_red: assert property (@(posedge clock) disable iff (reset)
      (stage_ff.valid && level_ff[15]) |=> rsp_red == 8'hFF)
      else $error("upper colormap half must have full red");

endmodule
`default_nettype wire
